[rtl/core/lir_pkg.sv]
// ----------------------------------------------------------------------------
// Linear interpolation resampler package
// Shared widths, constants, payload types and the sequencer state type.
// ----------------------------------------------------------------------------
package lir_pkg;

  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned STEP_W         = 21;
  localparam int unsigned POS_W          = 21;
  localparam int unsigned FRAC_W         = 16;
  localparam int unsigned DIFF_W         = SAMPLE_W + 1;
  localparam int unsigned PROD_W         = 2 * DIFF_W;

  localparam int unsigned ONE_Q16        = 65536;
  localparam int unsigned MAX_OUT_PER_IN = 16;
  localparam int unsigned STEP_MIN       = ONE_Q16 / MAX_OUT_PER_IN;
  localparam int unsigned STEP_MAX       = 1048576;
  localparam int unsigned STEP_RESET     = 65536;

  // Both queues hold two entries; the depth must stay a power of two.
  localparam int unsigned FIFO_DEPTH     = 2;
  localparam int unsigned FIFO_PTR_W     = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       final_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       has_sample;
    logic                       final_out;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INTERP,
    ST_IEMIT,
    ST_HOLD
  } seq_state_e;

endpackage

[rtl/core/linear_interp_resampler.sv]
// ----------------------------------------------------------------------------
// Linear interpolation resampler
// Flow: a request is written into the front queue and loaded by the sequencer,
//   whose multiply and emit states then push its results into the result queue.
// Sequencing: an item is loaded in ST_IDLE; each interpolated result passes
//   ST_INTERP, which multiplies, and ST_IEMIT; ST_HOLD emits held results and
//   ST_INTERP closes each interval. The single 17x17 product is registered.
// Reset: rst_ni is asynchronous, active low; it empties both queues, clears
//   the interpolation state and sets the step to 1.0 (equal rates).
// ----------------------------------------------------------------------------
module linear_interp_resampler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input request queue side.
  input  logic                        push,
  output logic                        full,
  input  lir_pkg::in_item_t           in_i,
  // Result queue side.
  output logic                        empty,
  input  logic                        pop,
  output lir_pkg::out_item_t          out_o,
  // Step register, unsigned Q5.16 input-to-output rate ratio.
  input  logic                        cfg_we_i,
  input  logic [lir_pkg::STEP_W-1:0]  cfg_wdata_i
);

  // The front end only buffers input requests so that a new sample can be
  // taken while the sequencer is still walking the previous interval.
  logic              fe_valid;
  logic              fe_pop;
  lir_pkg::in_item_t fe_item;

  // Results travel from the sequencer into a small queue, which decouples
  // the sequencer from a consumer that stalls with pop held low.
  logic               oq_full;
  logic               oq_push;
  lir_pkg::out_item_t oq_item;

  lir_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_i),
    .full_o  (full),
    .valid_o (fe_valid),
    .item_o  (fe_item),
    .pop_i   (fe_pop)
  );

  // The sequencer advances the output position by the saturated step. Each
  // interpolated result passes a multiply state and an emit state; after a
  // sample marked final it repeats that sample up to the block end and flags
  // the last result, or emits an empty flagged marker if none falls there.
  lir_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (fe_valid),
    .item_i       (fe_item),
    .item_pop_o   (fe_pop),
    .res_full_i   (oq_full),
    .res_push_o   (oq_push),
    .res_o        (oq_item)
  );

  lir_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (oq_push),
    .item_i  (oq_item),
    .full_o  (oq_full),
    .empty_o (empty),
    .item_o  (out_o),
    .pop_i   (pop)
  );

endmodule

[rtl/core/lir_front.sv]
// ----------------------------------------------------------------------------
// Resampler front end
// Accepts input requests and queues them for the interpolation sequencer.
// ----------------------------------------------------------------------------
module lir_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lir_pkg::in_item_t item_i,
  output logic             full_o,
  output logic             valid_o,
  output lir_pkg::in_item_t item_o,
  input  logic             pop_i
);

  lir_pkg::in_item_t                  mem_q [lir_pkg::FIFO_DEPTH];
  logic [lir_pkg::FIFO_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [lir_pkg::FIFO_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [lir_pkg::FIFO_CNT_W-1:0]     cnt_q, cnt_d;
  logic                               wr_en, rd_en;

  assign full_o  = (cnt_q == lir_pkg::FIFO_CNT_W'(lir_pkg::FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    unique case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[rtl/core/lir_outq.sv]
// ----------------------------------------------------------------------------
// Resampler result queue
// Holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module lir_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lir_pkg::out_item_t item_i,
  output logic               full_o,
  output logic               empty_o,
  output lir_pkg::out_item_t item_o,
  input  logic               pop_i
);

  lir_pkg::out_item_t                 mem_q [lir_pkg::FIFO_DEPTH];
  logic [lir_pkg::FIFO_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [lir_pkg::FIFO_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [lir_pkg::FIFO_CNT_W-1:0]     cnt_q, cnt_d;
  logic                               wr_en, rd_en;

  assign full_o  = (cnt_q == lir_pkg::FIFO_CNT_W'(lir_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    unique case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[rtl/core/lir_back.sv]
// ----------------------------------------------------------------------------
// Resampler interpolation sequencer
// Walks the output position across each input interval and emits results.
// ----------------------------------------------------------------------------
module lir_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lir_pkg::STEP_W-1:0]    cfg_wdata_i,
  input  logic                          item_valid_i,
  input  lir_pkg::in_item_t             item_i,
  output logic                          item_pop_o,
  input  logic                          res_full_i,
  output logic                          res_push_o,
  output lir_pkg::out_item_t            res_o
);

  localparam logic [lir_pkg::POS_W-1:0]  ONE_POS  = lir_pkg::POS_W'(lir_pkg::ONE_Q16);
  localparam logic [lir_pkg::POS_W:0]    ONE_EXT  = (lir_pkg::POS_W + 1)'(lir_pkg::ONE_Q16);
  localparam logic [lir_pkg::POS_W:0]    TWO_EXT  =
    (lir_pkg::POS_W + 1)'(2 * lir_pkg::ONE_Q16);
  localparam logic [lir_pkg::STEP_W-1:0] S_MIN    = lir_pkg::STEP_W'(lir_pkg::STEP_MIN);
  localparam logic [lir_pkg::STEP_W-1:0] S_MAX    = lir_pkg::STEP_W'(lir_pkg::STEP_MAX);
  localparam logic [lir_pkg::STEP_W-1:0] S_RESET  = lir_pkg::STEP_W'(lir_pkg::STEP_RESET);

  lir_pkg::seq_state_e                state_q, state_d;
  logic [lir_pkg::STEP_W-1:0]         step_q;
  logic signed [lir_pkg::SAMPLE_W-1:0] prev_q, prev_d;
  logic signed [lir_pkg::SAMPLE_W-1:0] cur_q, cur_d;
  logic                               fin_q, fin_d;
  logic                               have_prev_q, have_prev_d;
  logic                               emitted_q, emitted_d;
  logic [lir_pkg::POS_W-1:0]          pos_q, pos_d;
  logic signed [lir_pkg::PROD_W-1:0]  prod_q, prod_d;

  logic [lir_pkg::POS_W:0]            nxt_pos;
  logic                               pos_lt_one;
  logic signed [lir_pkg::DIFF_W-1:0]  diff;
  logic signed [lir_pkg::DIFF_W-1:0]  frac_s;
  logic signed [lir_pkg::PROD_W-1:0]  prod_biased;
  logic [lir_pkg::SAMPLE_W-1:0]       interp;

  assign nxt_pos    = {1'b0, pos_q} + (lir_pkg::POS_W + 1)'(step_q);
  assign pos_lt_one = (pos_q < ONE_POS);
  assign diff       = {cur_q[lir_pkg::SAMPLE_W-1], cur_q}
                    - {prev_q[lir_pkg::SAMPLE_W-1], prev_q};
  assign frac_s     = {1'b0, pos_q[lir_pkg::FRAC_W-1:0]};

  // Truncation toward zero: a negative product is biased up before the shift.
  assign prod_biased = prod_q + (prod_q[lir_pkg::PROD_W-1]
                     ? lir_pkg::PROD_W'(lir_pkg::ONE_Q16 - 1) : '0);
  assign interp      = prev_q + prod_biased[lir_pkg::FRAC_W +: lir_pkg::SAMPLE_W];

  // Step register, saturated to the supported range as it is written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_RESET;
    end else if (cfg_we_i) begin
      if (cfg_wdata_i < S_MIN) begin
        step_q <= S_MIN;
      end else if (cfg_wdata_i > S_MAX) begin
        step_q <= S_MAX;
      end else begin
        step_q <= cfg_wdata_i;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lir_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          if (have_prev_q) begin
            state_d = lir_pkg::ST_INTERP;
          end else if (item_i.final_in) begin
            state_d = lir_pkg::ST_HOLD;
          end
        end
      end
      lir_pkg::ST_INTERP: begin
        if (pos_lt_one) begin
          state_d = lir_pkg::ST_IEMIT;
        end else begin
          state_d = fin_q ? lir_pkg::ST_HOLD : lir_pkg::ST_IDLE;
        end
      end
      lir_pkg::ST_IEMIT: begin
        if (!res_full_i) begin
          state_d = lir_pkg::ST_INTERP;
        end
      end
      lir_pkg::ST_HOLD: begin
        if (!pos_lt_one && (emitted_q || !res_full_i)) begin
          state_d = lir_pkg::ST_IDLE;
        end
      end
      default: state_d = lir_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    item_pop_o  = 1'b0;
    res_push_o  = 1'b0;
    res_o       = '0;
    prev_d      = prev_q;
    cur_d       = cur_q;
    fin_d       = fin_q;
    have_prev_d = have_prev_q;
    emitted_d   = emitted_q;
    pos_d       = pos_q;
    prod_d      = prod_q;
    unique case (state_q)
      lir_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          cur_d      = item_i.sample;
          fin_d      = item_i.final_in;
          emitted_d  = 1'b0;
          if (!have_prev_q) begin
            prev_d      = item_i.sample;
            have_prev_d = 1'b1;
          end
        end
      end
      lir_pkg::ST_INTERP: begin
        if (pos_lt_one) begin
          prod_d = diff * frac_s;
        end else begin
          pos_d  = pos_q - ONE_POS;
          prev_d = cur_q;
        end
      end
      lir_pkg::ST_IEMIT: begin
        if (!res_full_i) begin
          res_push_o       = 1'b1;
          res_o.out_sample = interp;
          res_o.has_sample = 1'b1;
          // Last overall only if the hold phase that follows has nothing to emit.
          res_o.final_out  = fin_q && (nxt_pos >= TWO_EXT);
          pos_d            = nxt_pos[lir_pkg::POS_W-1:0];
          emitted_d        = 1'b1;
        end
      end
      lir_pkg::ST_HOLD: begin
        if (pos_lt_one) begin
          if (!res_full_i) begin
            res_push_o       = 1'b1;
            res_o.out_sample = cur_q;
            res_o.has_sample = 1'b1;
            res_o.final_out  = (nxt_pos >= ONE_EXT);
            pos_d            = nxt_pos[lir_pkg::POS_W-1:0];
            emitted_d        = 1'b1;
          end
        end else if (emitted_q || !res_full_i) begin
          if (!emitted_q) begin
            res_push_o      = 1'b1;
            res_o.final_out = 1'b1;
          end
          prev_d      = '0;
          have_prev_d = 1'b0;
          pos_d       = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lir_pkg::ST_IDLE;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      pos_q       <= '0;
      emitted_q   <= 1'b0;
      fin_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
      pos_q       <= pos_d;
      emitted_q   <= emitted_d;
      fin_q       <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    prod_q <= prod_d;
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_emit_pos_in_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lir_pkg::ST_IEMIT) |-> (pos_q < ONE_POS))
    else $error("interpolation emitted outside the current interval");

  a_pos_zero_without_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_prev_q |-> (pos_q == '0))
    else $error("output position moved before the first sample");

  a_busy_has_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != lir_pkg::ST_IDLE) |-> have_prev_q)
    else $error("sequencer busy without a primed previous sample");

endmodule

[bench/lir_checker.sv]
// ----------------------------------------------------------------------------
// Linear interpolation resampler checker
// Watches the request, result and step channels. It computes the samples that
// each accepted request owes and compares every popped result with them in
// order.
// ----------------------------------------------------------------------------
module lir_checker
  import lir_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                full_i,
  input  in_item_t            req_i,
  input  logic                empty_i,
  input  logic                pop_i,
  input  out_item_t           res_i,
  input  logic                cfg_we_i,
  input  logic [STEP_W-1:0]   cfg_wdata_i,
  output int unsigned         owed_o,
  output int unsigned         fails_o
);

  logic [STEP_W-1:0]          step_reg;
  logic signed [SAMPLE_W-1:0] last_sample;
  logic                       primed;
  logic [31:0]                out_pos;
  out_item_t                  owed_q[$];
  int unsigned                fails = 0;

  assign fails_o = fails;

  // Interpolates between two samples with a Q0.16 fraction, rounding toward zero.
  function automatic logic signed [SAMPLE_W-1:0] blend(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic [31:0]                frac
  );
    longint diff;
    longint prod;
    longint part;
    diff = longint'(b) - longint'(a);
    prod = diff * longint'(frac);
    if (prod < 0) part = -((-prod) >>> 16);
    else part = prod >>> 16;
    return SAMPLE_W'(longint'(a) + part);
  endfunction

  function automatic out_item_t make_out(
    input logic signed [SAMPLE_W-1:0] value,
    input logic                       has,
    input logic                       fin
  );
    out_item_t r;
    r.out_sample = value;
    r.has_sample = has;
    r.final_out  = fin;
    return r;
  endfunction

  task automatic resample(input in_item_t req);
    int unsigned step;
    int unsigned made;
    out_item_t   r;
    step = step_reg;
    if (step < STEP_MIN) step = STEP_MIN;
    if (step > STEP_MAX) step = STEP_MAX;
    made = 0;
    if (primed) begin
      while (out_pos < ONE_Q16) begin
        owed_q.push_back(make_out(blend(last_sample, req.sample, out_pos), 1'b1, 1'b0));
        made++;
        out_pos += step;
      end
      out_pos -= ONE_Q16;
    end
    last_sample = req.sample;
    primed      = 1'b1;
    if (req.final_in) begin
      // Positions past the last sample but below the sample count repeat it.
      while (out_pos < ONE_Q16) begin
        owed_q.push_back(make_out(req.sample, 1'b1, 1'b0));
        made++;
        out_pos += step;
      end
      if (made == 0) begin
        owed_q.push_back(make_out('0, 1'b0, 1'b1));
      end else begin
        r = owed_q.pop_back();
        r.final_out = 1'b1;
        owed_q.push_back(r);
      end
      last_sample = '0;
      primed      = 1'b0;
      out_pos     = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      step_reg    = STEP_W'(STEP_RESET);
      last_sample = '0;
      primed      = 1'b0;
      out_pos     = '0;
      owed_q.delete();
    end else begin
      if (pop_i && !empty_i) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result: out_sample %0d has_sample %0b final_out %0b",
                 res_i.out_sample, res_i.has_sample, res_i.final_out);
          fails++;
        end else begin
          want = owed_q.pop_front();
          if (res_i.out_sample !== want.out_sample) begin
            $error("out_sample: expected %0d, got %0d", want.out_sample, res_i.out_sample);
            fails++;
          end
          if (res_i.has_sample !== want.has_sample) begin
            $error("has_sample: expected %0b, got %0b", want.has_sample, res_i.has_sample);
            fails++;
          end
          if (res_i.final_out !== want.final_out) begin
            $error("final_out: expected %0b, got %0b", want.final_out, res_i.final_out);
            fails++;
          end
        end
      end
      if (push_i && !full_i) resample(req_i);
      if (cfg_we_i) step_reg = cfg_wdata_i;
    end
    owed_o = owed_q.size();
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Linear interpolation resampler testbench
// Feeds whole audio blocks at many step settings, from the saturated tiny
// step to the largest one, with random gaps on the request side and random
// stalls on the result side. A checker beside the block predicts every
// result and compares it in order.
// ----------------------------------------------------------------------------
module testbench;
  import lir_pkg::*;

  // Cycles allowed after the last owed result before the step is rewritten
  // and before the verdict; a request that owes nothing can still be in flight.
  localparam int unsigned SETTLE_CYCLES = 40;
  // Cycles without any accepted request or result before the run is abandoned.
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS  = 400;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              push      = 1'b0;
  logic              full;
  in_item_t          req       = '0;
  logic              empty;
  logic              pop       = 1'b0;
  out_item_t         res;
  logic              cfg_we    = 1'b0;
  logic [STEP_W-1:0] cfg_wdata = '0;

  int unsigned       owed;
  int unsigned       fails;
  int unsigned       sent = 0;

  // Idling modes, switched per phase so that busy and lazy stretches alternate.
  bit                tx_lazy = 1'b0;
  bit                rx_lazy = 1'b0;

  always #4 clk_i = ~clk_i;

  linear_interp_resampler uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (req),
    .empty       (empty),
    .pop         (pop),
    .out_o       (res),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  lir_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (full),
    .req_i       (req),
    .empty_i     (empty),
    .pop_i       (pop),
    .res_i       (res),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .owed_o      (owed),
    .fails_o     (fails)
  );

  // Result side. After each popped result a random stall is drawn
  // while the lazy mode is on; pop stays high otherwise.
  bit          pop_taken = 1'b0;
  int unsigned pop_wait  = 0;

  always @(posedge clk_i) begin
    pop_taken <= pop && !empty;
  end

  always @(negedge clk_i) begin
    if (pop_taken) pop_wait = rx_lazy ? $urandom_range(0, 15) : 0;
    if (pop_wait != 0) begin
      pop <= 1'b0;
      pop_wait--;
    end else begin
      pop <= 1'b1;
    end
  end

  // Watchdog: any accepted request or result restarts the count.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offers one request after a random gap and returns at the falling edge
  // after it was taken. Push stays high so that back-to-back requests keep it
  // asserted without a drop inside one time step.
  task automatic send(input logic signed [SAMPLE_W-1:0] smp, input logic fin);
    int unsigned gap;
    in_item_t    item;
    gap           = tx_lazy ? $urandom_range(0, 15) : 0;
    item.sample   = smp;
    item.final_in = fin;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    req  <= item;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    sent++;
  endtask

  // The step is only rewritten once every owed result has come out and the
  // block has had time to finish any request that owed nothing.
  task automatic set_step(input logic [STEP_W-1:0] value);
    push <= 1'b0;
    while (owed != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // One audio block with the final flag on its last sample. Samples mix full
  // random values, the rails and slowly moving signal.
  task automatic send_block(input int unsigned len);
    logic signed [SAMPLE_W-1:0] smp;
    smp = SAMPLE_W'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 3))
        0, 1: smp = SAMPLE_W'($urandom);
        2: begin
          case ($urandom_range(0, 4))
            0: smp = 16'sh7fff;
            1: smp = 16'sh8000;
            2: smp = 16'sh0000;
            3: smp = 16'shffff;
            default: smp = 16'sh0001;
          endcase
        end
        default: smp = smp + SAMPLE_W'($urandom_range(0, 512)) - 16'sd256;
      endcase
      send(smp, i == len - 1);
    end
  endtask

  // Steps favor upsampling, which yields the most results; the rest spread
  // over downsampling, the whole register and the saturation corners.
  function automatic logic [STEP_W-1:0] draw_step();
    case ($urandom_range(0, 5))
      0, 1: return STEP_W'($urandom_range(STEP_MIN, ONE_Q16));
      2: return STEP_W'($urandom_range(ONE_Q16, STEP_MAX));
      3: return STEP_W'($urandom_range(0, 2**STEP_W - 1));
      default: begin
        case ($urandom_range(0, 5))
          0: return '0;
          1: return STEP_W'(STEP_MIN - 1);
          2: return STEP_W'(STEP_MIN);
          3: return STEP_W'(STEP_MAX);
          4: return STEP_W'(STEP_MAX + 1);
          default: return STEP_W'(2**STEP_W - 1);
        endcase
      end
    endcase
  endfunction

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Equal rates straight out of reset: full-swing samples are copied, and a
    // block of a single final sample gives that sample, flagged final.
    send(16'sh7fff, 1'b0);
    send(16'sh8000, 1'b0);
    send(16'sh7fff, 1'b0);
    send(16'sh0000, 1'b0);
    send(16'shffff, 1'b1);
    send(16'sh8000, 1'b1);

    // A zero step saturates to the smallest one: sixteen outputs per
    // interval across the widest possible difference, then sixteen repeats.
    tx_lazy = 1'b1;
    rx_lazy = 1'b1;
    set_step('0);
    send(16'sh8000, 1'b0);
    send(16'sh7fff, 1'b0);
    send(16'sh7fff, 1'b1);

    // A step of three leaves no output position in the final interval, so
    // the block closes with the empty end marker.
    set_step(21'd196608);
    send(16'sd100, 1'b0);
    send(-16'sd200, 1'b0);
    send(16'sd300, 1'b1);

    // The all-ones step saturates to the largest one; most intervals owe nothing.
    set_step(STEP_W'(2**STEP_W - 1));
    send(16'sd5, 1'b0);
    send(-16'sd6, 1'b0);
    send(16'sd7, 1'b0);
    send(-16'sd8, 1'b1);

    // Random phases: a new step, then a few whole blocks. Every phase starts
    // with the sender held off until all owed results have come out.
    while (sent < RANDOM_ITEMS + 16) begin
      set_step(draw_step());
      tx_lazy = $urandom_range(0, 2) != 0;
      rx_lazy = $urandom_range(0, 2) != 0;
      repeat ($urandom_range(1, 4)) send_block($urandom_range(1, 12));
    end

    push <= 1'b0;
    while (owed != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
